// ===== src/edq_pkg.sv =====
// Package: shared constants and the arctangent table for the Euler to quaternion converter.
`default_nettype none
package edq_pkg;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned AngW = 16;
  localparam int unsigned TrigW = 32;
  localparam int unsigned OutW = 16;
  localparam logic signed [16:0] QuarterTurn = 17'sd11520;
  localparam logic signed [16:0] HalfTurn = 17'sd23040;
  localparam logic [24:0] DegToRadQ30 = 25'd18740330;
  localparam logic [31:0] CordicInvGain = 32'd652032874;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0: r = 32'd843314857;
      5'd1: r = 32'd497837829;
      5'd2: r = 32'd263043837;
      5'd3: r = 32'd133525159;
      5'd4: r = 32'd67021687;
      5'd5: r = 32'd33543516;
      5'd6: r = 32'd16775851;
      5'd7: r = 32'd8388437;
      5'd8: r = 32'd4194283;
      5'd9: r = 32'd2097149;
      5'd10: r = 32'd1048576;
      5'd11: r = 32'd524288;
      5'd12: r = 32'd262144;
      5'd13: r = 32'd131072;
      5'd14: r = 32'd65536;
      5'd15: r = 32'd32768;
      5'd16: r = 32'd16384;
      5'd17: r = 32'd8192;
      5'd18: r = 32'd4096;
      5'd19: r = 32'd2048;
      5'd20: r = 32'd1024;
      5'd21: r = 32'd512;
      5'd22: r = 32'd256;
      5'd23: r = 32'd128;
      default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== src/edq_if.sv =====
// Interfaces: angle input channel and quaternion output channel.
`default_nettype none
interface edq_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] roll_deg;
  logic signed [15:0] pitch_deg;
  logic signed [15:0] yaw_deg;
  modport source(output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink(input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

interface edq_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

// ===== src/edq_cordic_lane.sv =====
// Pipelined half-angle sine/cosine lane: fold, degree to radian, unrolled CORDIC stages.
`default_nettype none
module edq_cordic_lane #(
  parameter int unsigned STEPS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [edq_pkg::AngW-1:0] angle_i,
  output logic signed [edq_pkg::TrigW-1:0] cos_o,
  output logic signed [edq_pkg::TrigW-1:0] sin_o
);
  localparam int unsigned XW = 34;
  localparam int unsigned ZW = 33;

  logic signed [16:0] h_fold;
  logic               flip_d;
  logic               negs_d;
  logic [13:0]        mag;
  logic [38:0]        rad_prod;

  logic signed [XW-1:0] x_q [0:STEPS];
  logic signed [XW-1:0] y_q [0:STEPS];
  logic signed [ZW-1:0] z_q [0:STEPS];
  logic                 flip_q [0:STEPS];
  logic                 negs_q [0:STEPS];
  logic signed [edq_pkg::TrigW-1:0] cos_q, sin_q;

  always_comb begin
    h_fold = 17'(angle_i);
    flip_d = 1'b0;
    if (h_fold > edq_pkg::QuarterTurn) begin
      h_fold = h_fold - edq_pkg::HalfTurn;
      flip_d = 1'b1;
    end else if (h_fold < -edq_pkg::QuarterTurn) begin
      h_fold = h_fold + edq_pkg::HalfTurn;
      flip_d = 1'b1;
    end
    negs_d = h_fold[16];
    mag = negs_d ? 14'(-h_fold) : 14'(h_fold);
    rad_prod = 39'(mag) * 39'(edq_pkg::DegToRadQ30) + 39'd64;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= XW'(edq_pkg::CordicInvGain);
      y_q[0] <= '0;
      z_q[0] <= ZW'(rad_prod[38:7]);
      flip_q[0] <= flip_d;
      negs_q[0] <= negs_d;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] Atan =
      $signed({1'b0, edq_pkg::atan_q30(5'(i))});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - Atan;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + Atan;
        end
        flip_q[i+1] <= flip_q[i];
        negs_q[i+1] <= negs_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= flip_q[STEPS] ? edq_pkg::TrigW'(-x_q[STEPS]) : edq_pkg::TrigW'(x_q[STEPS]);
      sin_q <= (flip_q[STEPS] ^ negs_q[STEPS]) ? edq_pkg::TrigW'(-y_q[STEPS])
                                                 : edq_pkg::TrigW'(y_q[STEPS]);
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;
endmodule
`default_nettype wire

// ===== src/edq_merge.sv =====
// Merge stage: pairwise products, triple products, sums, rounding and saturation.
`default_nettype none
module edq_merge #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic signed [edq_pkg::TrigW-1:0] cr_i, sr_i, cp_i, sp_i, cy_i, sy_i,
  output logic signed [edq_pkg::OutW-1:0]  quat_x_o,
  output logic signed [edq_pkg::OutW-1:0]  quat_y_o,
  output logic signed [edq_pkg::OutW-1:0]  quat_z_o,
  output logic signed [edq_pkg::OutW-1:0]  quat_w_o
);
  localparam int unsigned TW = edq_pkg::TrigW;
  localparam int unsigned PW = 2 * TW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned Sh = 60 - FRAC_BITS;
  localparam logic signed [PW-1:0] HalfQ30 = PW'(64'sd536870912);
  localparam logic signed [SW-1:0] Rnd = SW'(1) <<< (Sh - 1);

  function automatic logic signed [TW-1:0] rnd30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + HalfQ30) >>> 30;
    return TW'(t);
  endfunction

  function automatic logic signed [edq_pkg::OutW-1:0] fin(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] v;
    v = (s + Rnd) >>> Sh;
    if (v > SW'(32767)) return 16'sh7fff;
    if (v < -SW'(32768)) return 16'sh8000;
    return edq_pkg::OutW'(v);
  endfunction

  logic signed [TW-1:0] cysr_q, sycr_q, cycr_q, sysr_q, cp_q, sp_q;
  logic signed [PW-1:0] xa_q, xb_q, ya_q, yb_q, za_q, zb_q, wa_q, wb_q;
  logic signed [edq_pkg::OutW-1:0] qx_q, qy_q, qz_q, qw_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cysr_q <= rnd30(PW'(cy_i) * PW'(sr_i));
      sycr_q <= rnd30(PW'(sy_i) * PW'(cr_i));
      cycr_q <= rnd30(PW'(cy_i) * PW'(cr_i));
      sysr_q <= rnd30(PW'(sy_i) * PW'(sr_i));
      cp_q <= cp_i;
      sp_q <= sp_i;
      xa_q <= PW'(cysr_q) * PW'(cp_q);
      xb_q <= PW'(sycr_q) * PW'(sp_q);
      ya_q <= PW'(cycr_q) * PW'(sp_q);
      yb_q <= PW'(sysr_q) * PW'(cp_q);
      za_q <= PW'(sycr_q) * PW'(cp_q);
      zb_q <= PW'(cysr_q) * PW'(sp_q);
      wa_q <= PW'(cycr_q) * PW'(cp_q);
      wb_q <= PW'(sysr_q) * PW'(sp_q);
      qx_q <= fin(SW'(xa_q) - SW'(xb_q));
      qy_q <= fin(SW'(ya_q) + SW'(yb_q));
      qz_q <= fin(SW'(za_q) - SW'(zb_q));
      qw_q <= fin(SW'(wa_q) + SW'(wb_q));
    end
  end

  assign quat_x_o = qx_q;
  assign quat_y_o = qy_q;
  assign quat_z_o = qz_q;
  assign quat_w_o = qw_q;
endmodule
`default_nettype wire

// ===== src/euler_degrees_to_quaternion.sv =====
// Top level: three CORDIC lanes for roll, pitch, yaw and a merge stage to the quaternion.
// Throughput: one transaction per cycle; the whole pipeline advances when the
// output register is empty or being taken, so it stalls only on output backpressure.
// Reset: asynchronous active low, clears the stage valid bits only.
`default_nettype none
module euler_degrees_to_quaternion #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned QUAT_FRAC_BITS = 15
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  edq_in_if.sink    in_i,
  edq_out_if.source out_o
);
  localparam int unsigned Steps = (CORDIC_STEPS > edq_pkg::AtanEntries) ?
                                  edq_pkg::AtanEntries : CORDIC_STEPS;
  localparam int unsigned Depth = Steps + 5;

  logic             en;
  logic             in_fire;
  logic [Depth-1:0] vld_q;
  logic signed [edq_pkg::TrigW-1:0] cr, sr, cp, sp, cy, sy;

  assign en = !vld_q[Depth-1] || out_o.ready;
  assign in_fire = in_i.valid && en;
  assign in_i.ready = en;
  assign out_o.valid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_fire};
    end
  end

  edq_cordic_lane #(.STEPS(Steps)) u_roll (
    .clk_i(clk_i), .en_i(en), .angle_i(in_i.roll_deg), .cos_o(cr), .sin_o(sr)
  );
  edq_cordic_lane #(.STEPS(Steps)) u_pitch (
    .clk_i(clk_i), .en_i(en), .angle_i(in_i.pitch_deg), .cos_o(cp), .sin_o(sp)
  );
  edq_cordic_lane #(.STEPS(Steps)) u_yaw (
    .clk_i(clk_i), .en_i(en), .angle_i(in_i.yaw_deg), .cos_o(cy), .sin_o(sy)
  );

  edq_merge #(.FRAC_BITS(QUAT_FRAC_BITS)) u_merge (
    .clk_i(clk_i), .en_i(en),
    .cr_i(cr), .sr_i(sr), .cp_i(cp), .sp_i(sp), .cy_i(cy), .sy_i(sy),
    .quat_x_o(out_o.quat_x), .quat_y_o(out_o.quat_y),
    .quat_z_o(out_o.quat_z), .quat_w_o(out_o.quat_w)
  );

`ifndef ASSERT_OFF
  a_fire_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> vld_q[0]) else $error("accepted transaction not in first stage");
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[Depth-1] && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while output stalled");
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !vld_q[Depth-2]) |=> !vld_q[Depth-1])
    else $error("output valid without a transaction behind it");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_euler_degrees_to_quaternion.sv =====
// Testbench: checks the Euler angle to quaternion converter against a bit-exact predictor.
module tb_euler_degrees_to_quaternion;

  localparam int unsigned Steps = 16;
  localparam int unsigned FracBits = 15;
  localparam int unsigned Latency = Steps + 5;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned RandomItems = 600;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } quat_t;

  logic clk_i;
  logic rst_ni;
  edq_in_if in_ch ();
  edq_out_if out_ch ();

  euler_degrees_to_quaternion #(
    .CORDIC_STEPS(Steps),
    .QUAT_FRAC_BITS(FracBits)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_ch.sink),
    .out_o(out_ch.source)
  );

  quat_t expected_quats[$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned received = 0;
  int unsigned idle_cycles = 0;
  int unsigned idle_pct = 14;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint floor_shr(longint v, int unsigned s);
    return v >>> s;
  endfunction

  task automatic half_trig(input logic signed [15:0] raw, output longint c, output longint s);
    longint h, a, x, y, z, nx;
    bit flip;
    bit neg;
    int unsigned n;
    h = raw;
    flip = 1'b0;
    if (h > edq_pkg::QuarterTurn) begin
      h = h - edq_pkg::HalfTurn;
      flip = 1'b1;
    end else if (h < -edq_pkg::QuarterTurn) begin
      h = h + edq_pkg::HalfTurn;
      flip = 1'b1;
    end
    neg = h < 0;
    a = neg ? -h : h;
    z = (a * longint'(edq_pkg::DegToRadQ30) + 64) >>> 7;
    x = longint'(edq_pkg::CordicInvGain);
    y = 0;
    n = (Steps > edq_pkg::AtanEntries) ? edq_pkg::AtanEntries : Steps;
    for (int unsigned i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z = z - longint'(edq_pkg::atan_q30(5'(i)));
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z = z + longint'(edq_pkg::atan_q30(5'(i)));
      end
      x = nx;
    end
    if (neg) y = -y;
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic longint triple_q60(longint a, longint b, longint c);
    return floor_shr(a * b + (64'sd1 <<< 29), 30) * c;
  endfunction

  function automatic logic signed [15:0] round_sat(longint q60);
    longint v;
    v = floor_shr(q60 + (64'sd1 <<< (60 - FracBits - 1)), 60 - FracBits);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic predict_quat(input logic signed [15:0] r, input logic signed [15:0] p,
                              input logic signed [15:0] yw, output quat_t q);
    longint cr, sr, cp, sp, cy, sy;
    half_trig(r, cr, sr);
    half_trig(p, cp, sp);
    half_trig(yw, cy, sy);
    q.qx = round_sat(triple_q60(cy, sr, cp) - triple_q60(sy, cr, sp));
    q.qy = round_sat(triple_q60(cy, cr, sp) + triple_q60(sy, sr, cp));
    q.qz = round_sat(triple_q60(sy, cr, cp) - triple_q60(cy, sr, sp));
    q.qw = round_sat(triple_q60(cy, cr, cp) + triple_q60(sy, sr, sp));
  endtask

  task automatic send_angles(input logic signed [15:0] r, input logic signed [15:0] p,
                             input logic signed [15:0] yw);
    quat_t q;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    predict_quat(r, p, yw, q);
    in_ch.valid <= 1'b1;
    in_ch.roll_deg <= r;
    in_ch.pitch_deg <= p;
    in_ch.yaw_deg <= yw;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_quats.push_back(q);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_quats.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(46080) - 23040);
      2: return 16'($urandom_range(200) - 100);
      default: return 16'($urandom_range(4) * 11520 - 23040 + $urandom_range(2) - 1);
    endcase
  endfunction

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    quat_t e;
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        received++;
        if (expected_quats.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction x=%0d y=%0d z=%0d w=%0d", $time,
                   out_ch.quat_x, out_ch.quat_y, out_ch.quat_z, out_ch.quat_w);
        end else begin
          e = expected_quats.pop_front();
          if (out_ch.quat_x !== e.qx) begin
            errors++;
            $display("%0t: quat_x expected %0d actual %0d", $time, e.qx, out_ch.quat_x);
          end
          if (out_ch.quat_y !== e.qy) begin
            errors++;
            $display("%0t: quat_y expected %0d actual %0d", $time, e.qy, out_ch.quat_y);
          end
          if (out_ch.quat_z !== e.qz) begin
            errors++;
            $display("%0t: quat_z expected %0d actual %0d", $time, e.qz, out_ch.quat_z);
          end
          if (out_ch.quat_w !== e.qw) begin
            errors++;
            $display("%0t: quat_w expected %0d actual %0d", $time, e.qw, out_ch.quat_w);
          end
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("euler_degrees_to_quaternion: mismatch");
        $finish;
      end
    end
  end

  task automatic test_extremes();
    logic signed [15:0] vals[10] = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd11520, -16'sd11520,
                                     16'sd23041, -16'sd23041, 16'sh7fff, 16'sh8000, 16'sd1};
    foreach (vals[i]) send_angles(vals[i], vals[(i + 3) % 10], vals[(i + 7) % 10]);
    send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'sd5760, 16'sd0, 16'sd0);
    send_angles(16'sd0, 16'sd5760, 16'sd0);
    send_angles(16'sd0, 16'sd0, 16'sd5760);
    send_angles(-16'sd1, -16'sd1, -16'sd1);
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat ($urandom_range(Latency)) @(negedge clk_i);
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 3) idle_pct = 0;
      if (i == count / 2) idle_pct = 14;
      send_angles(rand_angle(), rand_angle(), rand_angle());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.roll_deg = '0;
    in_ch.pitch_deg = '0;
    in_ch.yaw_deg = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_drain_pause();
    test_random(RandomItems);
    wait_drained();
    repeat (Latency + 5) @(negedge clk_i);
    $display("Sent %0d angle triples (boundaries, fold points, full 16-bit range), got %0d",
             sent, received);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("euler_degrees_to_quaternion: match");
    end else begin
      $display("euler_degrees_to_quaternion: mismatch");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/edq_pkg.sv
src/edq_if.sv
src/edq_cordic_lane.sv
src/edq_merge.sv
src/euler_degrees_to_quaternion.sv
tb/tb_euler_degrees_to_quaternion.sv
